@@ rtl/lsc_pkg.sv @@
// Shared types and constants of the light strobe controller.
`default_nettype none

package lsc_pkg;

   // Configuration register map.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VCC_FULL_SCALE = 1'd1;

   localparam int THR_W = 11;
   localparam int VCC_W = 12;
   localparam logic [THR_W-1:0] THR_RESET = 11'd1100;
   localparam logic [VCC_W-1:0] VCC_RESET = 12'd2032;

   // Tick sequencing.
   localparam int TICK_W = 6;
   localparam logic [TICK_W-1:0] TICK_FIRST = 6'd1;
   localparam logic [TICK_W-1:0] TICK_WRAP  = 6'd50;
   localparam logic [2:0]        MOD5_LAST  = 3'd4;

   typedef struct packed {
      logic main_light_on;
      logic high_power_led;
      logic red_light_on;
      logic green_dim_on;
      logic swap_blinker_on;
      logic flasher_on;
   } light_levels_type;

   typedef struct packed {
      light_levels_type levels;
      logic             watchdog_kick;
   } out_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

@@ rtl/light_strobe_controller_top.sv @@
// Top level of the light strobe controller: tick sequencer, cell chains and output stage.
`default_nettype none

// Usage. Each word on the req_ channel is one 10 ms tick with two button
// levels and a supply sample; each tick yields exactly one rsp_ word with the
// light levels after that tick and the watchdog kick. A word is taken at a
// rising edge where its valid is high and its stall is low.
// An accepted tick's result is registered in the output register; while it
// is stalled there by rsp_stall, one more tick is taken into a skid register,
// after which req_stall stays high until the receiver drains the output. The
// block takes one tick per cycle while req_stall is low. The sample history
// and both button histories are shift chains of small cells; button two's
// moves each tick, button one's only after high power latched, the samples'
// every fifth tick before that. The sum (one subtract, one add) is compared
// every tenth tick to a precomputed limit (threshold in summed sample units)
// that a bit-serial divider finds after reset and every csr_ write, with
// req_stall high during that run. Reset is synchronous and returns the
// config and tick state, histories, sample cells and valid flags to defaults.
module light_strobe_controller_top #(
   parameter int AVG_DEPTH     = 16,
   parameter int DEBOUNCE_BITS = 32,
   parameter int SAMPLE_BITS   = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [0:0]             csr_index,
   input  logic [11:0]            csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_button_one_low,
   input  logic                   req_button_two_low,
   input  logic [SAMPLE_BITS-1:0] req_supply_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_main_light_on,
   output logic                   rsp_high_power_led,
   output logic                   rsp_red_light_on,
   output logic                   rsp_green_dim_on,
   output logic                   rsp_swap_blinker_on,
   output logic                   rsp_flasher_on,
   output logic                   rsp_watchdog_kick
);

   import lsc_pkg::*;

   localparam int K_W   = THR_W + SAMPLE_BITS;
   localparam int NW    = K_W + 1;
   localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_DEPTH + 1);
   localparam int LIM_W = NW + $clog2(AVG_DEPTH + 1);

   // Configuration registers.
   logic [THR_W-1:0] thr_ff;
   logic [VCC_W-1:0] vcc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         vcc_ff <= VCC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: begin
               thr_ff <= csr_wdata[THR_W-1:0];
            end
            CSR_VCC_FULL_SCALE: begin
               vcc_ff <= csr_wdata[VCC_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The check floor(floor(sum/D) * vcc / full_scale) >= thr reduces to
   // sum >= ceil(thr * full_scale / vcc) * D, so the divide happens once per
   // configuration change instead of once per tick.
   logic             pending_ff;
   logic             div_start;
   div_status_type   div_status;
   logic [NW-1:0]    div_quotient;
   logic [K_W-1:0]   thr_scaled;
   logic [NW-1:0]    div_dividend;
   logic [LIM_W-1:0] limit_ff;
   logic             calc_busy;

   assign div_start    = pending_ff && !div_status.busy && !div_status.done;
   assign thr_scaled   = {thr_ff, {SAMPLE_BITS{1'b0}}} - K_W'(thr_ff);
   assign div_dividend = NW'(thr_scaled) + NW'(vcc_ff) - NW'(1);
   assign calc_busy    = pending_ff || div_status.busy || div_status.done;

   lsc_divider #(.NW(NW), .DV_W(VCC_W)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (vcc_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b1;
      end else if (csr_we) begin
         pending_ff <= 1'b1;
      end else if (div_start) begin
         pending_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_status.done) begin
         if (vcc_ff == '0) begin
            // A zero full scale makes the voltage zero: only a zero threshold passes.
            limit_ff <= (thr_ff == '0) ? '0 : '1;
         end else begin
            limit_ff <= LIM_W'(div_quotient) * LIM_W'(AVG_DEPTH);
         end
      end
   end

   // Handshake and output stage.
   logic         out_v_ff;
   logic         skid_v_ff;
   out_word_type out_ff;
   out_word_type skid_ff;
   out_word_type word_in;
   logic         accept;
   logic         rsp_take;

   assign req_stall = skid_v_ff || calc_busy;
   assign accept    = req_valid && !req_stall;
   assign rsp_take  = out_v_ff && !rsp_stall;

   // Tick state.
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [2:0]        mod5_ff, mod5_in;
   logic              hp_ff, hp_in;
   logic              strobe_ff, strobe_in;
   logic              strobe_phase_ff, strobe_phase_in;
   logic              blink_ff, blink_in;
   logic              flash_phase_ff, flash_phase_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   light_levels_type  levels_ff, levels_in;

   logic                               sample_tick;
   logic                               tenth_tick;
   logic                               strobe_tick;
   logic                               push;
   logic [AVG_DEPTH*SAMPLE_BITS-1:0]   sample_taps;
   logic [DEBOUNCE_BITS-2:0]           mode_taps;
   logic [DEBOUNCE_BITS-2:0]           blink_taps;
   logic [DEBOUNCE_BITS-1:0]           mode_hist;
   logic [DEBOUNCE_BITS-1:0]           blink_hist;
   logic [SAMPLE_BITS-1:0]             oldest;
   logic [SUM_W-1:0]                   new_sum;

   // The tick counter runs 1..50; 50 is a multiple of ten, so a modulo-5
   // phase plus the counter's low bit give the every-5th and every-10th ticks.
   assign sample_tick = (mod5_ff == '0);
   assign tenth_tick  = sample_tick && !tick_ff[0];
   assign strobe_tick = (tick_ff[1:0] == 2'b00);

   // The chains keep the older bits; the current button level completes each history.
   assign mode_hist  = {mode_taps, req_button_one_low};
   assign blink_hist = {blink_taps, req_button_two_low};
   assign oldest     = sample_taps[(AVG_DEPTH-1)*SAMPLE_BITS +: SAMPLE_BITS];
   assign new_sum    = sum_ff - SUM_W'(oldest) + SUM_W'(req_supply_sample);

   lsc_chain #(.WIDTH(SAMPLE_BITS), .DEPTH(AVG_DEPTH)) u_sample_chain (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept && push),
      .din      (req_supply_sample),
      .taps     (sample_taps)
   );

   lsc_chain #(.WIDTH(1), .DEPTH(DEBOUNCE_BITS - 1)) u_mode_chain (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept && hp_ff),
      .din      (req_button_one_low),
      .taps     (mode_taps)
   );

   lsc_chain #(.WIDTH(1), .DEPTH(DEBOUNCE_BITS - 1)) u_blink_chain (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .din      (req_button_two_low),
      .taps     (blink_taps)
   );

   always_comb begin
      tick_in         = tick_ff;
      mod5_in         = (mod5_ff == MOD5_LAST) ? 3'd0 : mod5_ff + 3'd1;
      hp_in           = hp_ff;
      strobe_in       = strobe_ff;
      strobe_phase_in = strobe_phase_ff;
      blink_in        = blink_ff;
      flash_phase_in  = flash_phase_ff;
      sum_in          = sum_ff;
      levels_in       = levels_ff;
      push            = 1'b0;

      if (hp_ff) begin
         // Button one debounce only runs once high power has latched.
         if (&mode_hist) begin
            strobe_in = 1'b1;
         end else if (~|mode_hist) begin
            strobe_in               = 1'b0;
            levels_in.main_light_on = 1'b1;
         end
         if (strobe_in && strobe_tick) begin
            levels_in.main_light_on = strobe_phase_ff;
            strobe_phase_in         = !strobe_phase_ff;
         end
         levels_in.red_light_on = 1'b1;
         levels_in.green_dim_on = 1'b1;
      end else if (sample_tick) begin
         push   = 1'b1;
         sum_in = new_sum;
         if (tenth_tick && (LIM_W'(new_sum) >= limit_ff)) begin
            hp_in                    = 1'b1;
            levels_in.high_power_led = 1'b1;
         end
      end

      if (&blink_hist) begin
         blink_in = 1'b1;
      end else if (~|blink_hist) begin
         blink_in = 1'b0;
      end

      if (tick_ff >= TICK_WRAP) begin
         tick_in = TICK_FIRST;
         if (blink_in) begin
            levels_in.swap_blinker_on = 1'b1;
            levels_in.flasher_on      = flash_phase_ff;
            flash_phase_in            = !flash_phase_ff;
         end else begin
            levels_in.swap_blinker_on = 1'b0;
            levels_in.flasher_on      = 1'b0;
            flash_phase_in            = 1'b1;
         end
      end else begin
         tick_in = tick_ff + TICK_W'(1);
      end

      word_in.levels        = levels_in;
      word_in.watchdog_kick = tenth_tick;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= TICK_FIRST;
         mod5_ff         <= 3'd1;
         hp_ff           <= 1'b0;
         strobe_ff       <= 1'b0;
         strobe_phase_ff <= 1'b1;
         blink_ff        <= 1'b0;
         flash_phase_ff  <= 1'b1;
         sum_ff          <= '0;
         levels_ff       <= '0;
      end else if (accept) begin
         tick_ff         <= tick_in;
         mod5_ff         <= mod5_in;
         hp_ff           <= hp_in;
         strobe_ff       <= strobe_in;
         strobe_phase_ff <= strobe_phase_in;
         blink_ff        <= blink_in;
         flash_phase_ff  <= flash_phase_in;
         sum_ff          <= sum_in;
         levels_ff       <= levels_in;
      end
   end

   // Output register with one skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_take) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= accept;
         end
      end else if (accept) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_take) begin
         out_ff <= skid_v_ff ? skid_ff : word_in;
      end else if (accept) begin
         skid_ff <= word_in;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_main_light_on   = out_ff.levels.main_light_on;
   assign rsp_high_power_led  = out_ff.levels.high_power_led;
   assign rsp_red_light_on    = out_ff.levels.red_light_on;
   assign rsp_green_dim_on    = out_ff.levels.green_dim_on;
   assign rsp_swap_blinker_on = out_ff.levels.swap_blinker_on;
   assign rsp_flasher_on      = out_ff.levels.flasher_on;
   assign rsp_watchdog_kick   = out_ff.watchdog_kick;

   // High power never drops once latched.
   a_hp_sticky: assert property (@(posedge clock) disable iff (reset)
      hp_ff |=> hp_ff)
      else $error("high power latch dropped");

   // Strobe mode can only be chosen after high power latched.
   a_strobe_needs_hp: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> hp_ff)
      else $error("strobe mode without high power");

   // The skid entry is only filled behind a held output word.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid word without output word");

   // Tick counter stays within 1..50.
   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      (tick_ff >= TICK_FIRST) && (tick_ff <= TICK_WRAP))
      else $error("tick counter out of range");

endmodule

`default_nettype wire

@@ rtl/lsc_cell.sv @@
// One storage cell of a shift chain.
`default_nettype none

module lsc_cell #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else if (shift_en) begin
         data_ff <= din;
      end
   end

   assign dout = data_ff;

endmodule

`default_nettype wire

@@ rtl/lsc_chain.sv @@
// Row of identical cells; every shift moves each cell's word to its neighbor.
`default_nettype none

module lsc_chain #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  logic [WIDTH-1:0]       din,
   output logic [DEPTH*WIDTH-1:0] taps
);

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_head
            lsc_cell #(.WIDTH(WIDTH)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .din      (din),
               .dout     (taps[0 +: WIDTH])
            );
         end else begin : g_body
            lsc_cell #(.WIDTH(WIDTH)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .din      (taps[(i-1)*WIDTH +: WIDTH]),
               .dout     (taps[i*WIDTH +: WIDTH])
            );
         end
      end
   endgenerate

endmodule

`default_nettype wire

@@ rtl/lsc_divider.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module lsc_divider #(
   parameter int NW   = 22,
   parameter int DV_W = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NW-1:0]          dividend,
   input  logic [DV_W-1:0]        divisor,
   output lsc_pkg::div_status_type status,
   output logic [NW-1:0]          quotient
);

   import lsc_pkg::*;

   localparam int CNT_W = $clog2(NW);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [NW-1:0]    num_ff;
   logic [DV_W-1:0]  den_ff;
   logic [DV_W-1:0]  rem_ff;
   logic [NW-1:0]    quo_ff;

   logic [DV_W:0]    trial;
   logic             qbit;
   logic [DV_W-1:0]  rem_in;

   always_comb begin
      trial = {rem_ff, num_ff[NW-1]};
      qbit  = (trial >= {1'b0, den_ff});
      if (qbit) begin
         rem_in = DV_W'(trial - {1'b0, den_ff});
      end else begin
         rem_in = trial[DV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && (count_ff == '0)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         count_ff <= CNT_W'(NW - 1);
         num_ff   <= dividend;
         den_ff   <= divisor;
         rem_ff   <= '0;
         quo_ff   <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff - CNT_W'(1);
         num_ff   <= {num_ff[NW-2:0], 1'b0};
         rem_ff   <= rem_in;
         quo_ff   <= {quo_ff[NW-2:0], qbit};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire
